// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker module.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// next-cycle implication, checked through reset too
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/isaa_pkg.sv -----
// Shared types and constants for the IMU stillness / accel average block.
// No dependencies.
package isaa_pkg;

    localparam int WINDOW_DEF   = 512;
    localparam int QUEUE_DEPTH  = 8;
    localparam int SAMPLE_W     = 16;
    localparam int GYRO_LIM_W   = 15;
    localparam int NORM_W       = 32;
    localparam int RUN_W        = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int S_DATA_W     = 96;
    localparam int M_DATA_W     = 72;

    localparam logic [GYRO_LIM_W-1:0] GYRO_LIMIT_RST    = 15'd8;
    localparam logic [NORM_W-1:0]     NORM_SQ_MIN_RST   = 32'd14200236;
    localparam logic [NORM_W-1:0]     NORM_SQ_MAX_RST   = 32'd19568945;
    localparam logic [RUN_W-1:0]      STABLE_NEEDED_RST = 16'd400;
    localparam logic [RUN_W-1:0]      RUN_MAX           = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GYRO_LIMIT    = 2'd0,
        REG_NORM_SQ_MIN   = 2'd1,
        REG_NORM_SQ_MAX   = 2'd2,
        REG_STABLE_NEEDED = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GYRO_LIM_W-1:0] gyro_limit;
        logic [NORM_W-1:0]     norm_sq_min;
        logic [NORM_W-1:0]     norm_sq_max;
        logic [RUN_W-1:0]      stable_needed;
    } isaa_cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic                       still_now;
        logic [RUN_W-1:0]           run_length;
        logic                       calibrate;
    } isaa_item_t;

endpackage

// ----- hw/rtl/isaa_front.sv -----
// Front end: squares, gyro magnitude test, norm band test and run counter.
// Depends on isaa_pkg.
module isaa_front import isaa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  isaa_cfg_t           cfg,
    input  logic                in_valid,
    input  logic [S_DATA_W-1:0] in_data,
    output logic                push_valid,
    output isaa_item_t          push_item,
    output logic [1:0]          inflight
);

    logic                       f1_valid_reg;
    logic                       f1_gyro_ok_reg;
    logic [30:0]                f1_sq_reg [3];
    logic signed [SAMPLE_W-1:0] f1_accel_reg [3];

    logic                       f2_valid_reg;
    isaa_item_t                 f2_item_reg;
    logic [RUN_W-1:0]           run_reg;

    logic                       gyro_ok_next;
    logic [30:0]                sq_next [3];
    logic [NORM_W-1:0]          nsq;
    logic                       still;
    logic [RUN_W-1:0]           run_next;

    always_comb begin
        logic signed [SAMPLE_W-1:0] g;
        logic signed [SAMPLE_W-1:0] a;
        logic [SAMPLE_W:0]          mag;
        logic signed [31:0]         prod;
        gyro_ok_next = 1'b1;
        for (int i = 0; i < 3; i++) begin
            g    = in_data[i*SAMPLE_W +: SAMPLE_W];
            a    = in_data[(i+3)*SAMPLE_W +: SAMPLE_W];
            mag  = g[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {g[SAMPLE_W-1], g})
                                 : {1'b0, g};
            if (mag >= {2'b00, cfg.gyro_limit}) begin
                gyro_ok_next = 1'b0;
            end
            prod       = a * a;
            sq_next[i] = prod[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= in_valid;
        end
        if (in_valid) begin
            f1_gyro_ok_reg <= gyro_ok_next;
            for (int i = 0; i < 3; i++) begin
                f1_sq_reg[i]    <= sq_next[i];
                f1_accel_reg[i] <= in_data[(i+3)*SAMPLE_W +: SAMPLE_W];
            end
        end
    end

    // at most 3 * 2^30, fits in 32 bits
    assign nsq = {1'b0, f1_sq_reg[0]} + {1'b0, f1_sq_reg[1]} + {1'b0, f1_sq_reg[2]};
    assign still = f1_gyro_ok_reg && (nsq > cfg.norm_sq_min) && (nsq < cfg.norm_sq_max);

    always_comb begin
        if (!still) begin
            run_next = '0;
        end else if (run_reg == RUN_MAX) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + RUN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
            run_reg      <= '0;
        end else begin
            f2_valid_reg <= f1_valid_reg;
            if (f1_valid_reg) begin
                run_reg <= run_next;
            end
        end
        if (f1_valid_reg) begin
            f2_item_reg.accel_x    <= f1_accel_reg[0];
            f2_item_reg.accel_y    <= f1_accel_reg[1];
            f2_item_reg.accel_z    <= f1_accel_reg[2];
            f2_item_reg.still_now  <= still;
            f2_item_reg.run_length <= run_next;
            f2_item_reg.calibrate  <= (run_next >= cfg.stable_needed);
        end
    end

    assign push_valid = f2_valid_reg;
    assign push_item  = f2_item_reg;
    assign inflight   = {1'b0, f1_valid_reg} + {1'b0, f2_valid_reg};

endmodule

// ----- hw/rtl/isaa_queue.sv -----
// Small FIFO between front and back end.
// Depends on isaa_pkg.
module isaa_queue import isaa_pkg::*; (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push_valid,
    input  isaa_item_t                           push_item,
    input  logic                                 pop,
    output logic                                 out_valid,
    output isaa_item_t                           out_item,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    isaa_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH-1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
        end
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- hw/rtl/isaa_back.sv -----
// Back end: history ring, per-axis running sums, average and output register.
// Depends on isaa_pkg.
module isaa_back import isaa_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  isaa_item_t          q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int SHIFT = $clog2(WINDOW + 1) - 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    logic [3*SAMPLE_W-1:0] hist_mem [WINDOW];
    logic [PTR_W-1:0]      ptr_reg;
    logic                  wrapped_reg;

    logic                  adv;
    logic                  b1_valid_reg;
    logic                  b1_fresh_reg;
    isaa_item_t            b1_item_reg;
    logic [3*SAMPLE_W-1:0] old_reg;

    logic                  b2_valid_reg;
    isaa_item_t            b2_item_reg;
    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [SUM_W-1:0] sum_next [3];

    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic [3*SAMPLE_W-1:0] avg_next;

    function automatic logic [SAMPLE_W-1:0] sat_avg(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> SHIFT;
        if (q > SAT_HI) begin
            return SAT_HI[SAMPLE_W-1:0];
        end else if (q < SAT_LO) begin
            return SAT_LO[SAMPLE_W-1:0];
        end
        return q[SAMPLE_W-1:0];
    endfunction

    // whole back end moves together when the output slot frees up
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = q_valid && adv;

    // read-first ring: old sample comes out as the new one goes in
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            hist_mem[ptr_reg] <= {q_item.accel_z, q_item.accel_y, q_item.accel_x};
        end
        if (adv) begin
            old_reg <= hist_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            wrapped_reg  <= 1'b0;
            b1_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg <= q_pop;
            if (q_pop) begin
                if (ptr_reg == PTR_W'(WINDOW-1)) begin
                    ptr_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                end
            end
        end
        if (adv && q_pop) begin
            b1_item_reg  <= q_item;
            // entries not yet written since reset read as zero
            b1_fresh_reg <= !wrapped_reg;
        end
    end

    always_comb begin
        logic signed [SAMPLE_W-1:0] a_new [3];
        logic signed [SAMPLE_W-1:0] a_old [3];
        a_new[0] = b1_item_reg.accel_x;
        a_new[1] = b1_item_reg.accel_y;
        a_new[2] = b1_item_reg.accel_z;
        for (int i = 0; i < 3; i++) begin
            a_old[i]    = b1_fresh_reg ? '0 : $signed(old_reg[i*SAMPLE_W +: SAMPLE_W]);
            sum_next[i] = sum_reg[i] + SUM_W'(a_new[i]) - SUM_W'(a_old[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (adv) begin
            b2_valid_reg <= b1_valid_reg;
            if (b1_valid_reg) begin
                for (int i = 0; i < 3; i++) begin
                    sum_reg[i] <= sum_next[i];
                end
            end
        end
        if (adv && b1_valid_reg) begin
            b2_item_reg <= b1_item_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            avg_next[i*SAMPLE_W +: SAMPLE_W] = sat_avg(sum_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= b2_valid_reg;
        end
        if (adv && b2_valid_reg) begin
            out_data_reg <= {6'b000000, b2_item_reg.calibrate, b2_item_reg.run_length,
                             b2_item_reg.still_now, avg_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/imu_stationarity_and_accel_average_core.sv -----
// Top level of the IMU stillness detector with boxcar accel average.
// Depends on isaa_pkg, isaa_front, isaa_queue, isaa_back.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata: 6 x 16-bit samples
//  m_      | out | m_tvalid / m_tready  | m_tdata: averages, still, run, calibrate
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// One item per cycle sustained while m_tready is high; the history ring does one read and
// one write per item on a single port. Path: front f1, f2, queue, back b1, b2, output reg.
// Reset (aresetn low, synchronous) empties all stages; the ring needs no clearing
// pass, slots are treated as zero until the pointer first wraps.
// An output stall freezes the back end; the queue absorbs the front end's items
// and s_tready drops once it has no room left for them.
module imu_stationarity_and_accel_average_core import isaa_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
    input  logic [S_DATA_W-1:0]    s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // avg_x, avg_y, avg_z, still_now, run_length, calibrate, 6 zero bits
    output logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    isaa_cfg_t         cfg_reg;
    logic              in_take;
    logic              push_valid;
    isaa_item_t        push_item;
    logic [1:0]        inflight;
    logic              q_valid;
    isaa_item_t        q_item;
    logic              q_pop;
    logic [CNT_W-1:0]  q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gyro_limit    <= GYRO_LIMIT_RST;
            cfg_reg.norm_sq_min   <= NORM_SQ_MIN_RST;
            cfg_reg.norm_sq_max   <= NORM_SQ_MAX_RST;
            cfg_reg.stable_needed <= STABLE_NEEDED_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GYRO_LIMIT:    cfg_reg.gyro_limit    <= cfg_wdata[GYRO_LIM_W-1:0];
                REG_NORM_SQ_MIN:   cfg_reg.norm_sq_min   <= cfg_wdata[NORM_W-1:0];
                REG_NORM_SQ_MAX:   cfg_reg.norm_sq_max   <= cfg_wdata[NORM_W-1:0];
                REG_STABLE_NEEDED: cfg_reg.stable_needed <= cfg_wdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // reserve a queue slot for every item still inside the front end
    assign s_tready = ({1'b0, q_count} + (CNT_W+1)'(inflight)) < (CNT_W+1)'(QUEUE_DEPTH);
    assign in_take  = s_tvalid && s_tready;

    isaa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (in_take),
        .in_data    (s_tdata),
        .push_valid (push_valid),
        .push_item  (push_item),
        .inflight   (inflight)
    );

    isaa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (q_pop),
        .out_valid  (q_valid),
        .out_item   (q_item),
        .count      (q_count)
    );

    isaa_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- hw/rtl/isaa_checker.sv -----
// Port-level checks for the IMU stillness core, bound to the top level.
// Depends on isaa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isaa_checker import isaa_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic             still_now;
    logic [RUN_W-1:0] run_length;

    assign still_now  = m_tdata[48];
    assign run_length = m_tdata[64:49];

    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLY(a_motion_clears_run, aclk, aresetn, m_tvalid && !still_now, run_length == '0)
    `ASSERT_IMPLY(a_still_counts, aclk, aresetn, m_tvalid && still_now, run_length != '0)

endmodule

bind imu_stationarity_and_accel_average_core isaa_checker u_isaa_checker (.*);
